// ===== rtl/wpi_pkg.sv =====
// ----------------------------------------------------------------------------
// wpi_pkg
// Shared types and constants for the waypoint path interpolator.
// ----------------------------------------------------------------------------
package wpi_pkg;

    localparam int unsigned COORD_W  = 32;
    localparam int unsigned CORD_W   = 36;
    localparam int unsigned REM_W    = 40;
    localparam int unsigned ITER_W   = 5;
    localparam int unsigned QUOT_W   = 7;
    localparam int unsigned CNT_W    = 6;
    localparam int unsigned KBIT_W   = 3;
    localparam logic [29:0] GAIN_INV_Q30 = 30'd652032874;
    localparam logic [31:0] STEP_RESET   = 32'd6554;

    typedef enum logic [1:0] {
        OP_START    = 2'd0,
        OP_WAYPOINT = 2'd1,
        OP_GOAL     = 2'd2,
        OP_NONE     = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        SEL_LEN = 2'd0,
        SEL_X   = 2'd1,
        SEL_Y   = 2'd2
    } mul_sel_t;

    typedef struct packed {
        logic              load_in;
        logic              cordic_step;
        logic [ITER_W-1:0] iter;
        logic              mul_lo;
        logic              mul_hi;
        mul_sel_t          sel;
        logic              div_init;
        logic              div_step;
        logic [KBIT_W-1:0] div_k;
        logic              emit_start;
        logic              emit_point;
        logic              emit_last;
        logic              emit_goal;
        logic              commit_anchor;
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;
        logic cnt_zero;
        logic cnt_one;
    } dp_status_t;

endpackage

// ===== rtl/wpi_ctrl.sv =====
// ----------------------------------------------------------------------------
// wpi_ctrl
// Sequencer: CORDIC iterations, shared multiplier passes, division, emission.
// ----------------------------------------------------------------------------
module wpi_ctrl #(
    parameter int unsigned CORDIC_STEPS = 24
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [1:0]          s_op,
    input  wpi_pkg::dp_status_t status,
    output wpi_pkg::dp_cmd_t    cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_START, S_CORDIC, S_MLO, S_MHI, S_DIVI, S_DIV, S_EMIT, S_GOAL
    } state_t;

    state_t                     state_reg, state_next;
    logic [wpi_pkg::ITER_W-1:0] iter_reg, iter_next;
    logic [wpi_pkg::KBIT_W-1:0] k_reg, k_next;
    wpi_pkg::mul_sel_t          sel_reg, sel_next;
    logic                       goal_reg, goal_next;
    logic                       accept;

    assign s_ready = (state_reg == S_IDLE);
    assign accept  = s_valid && s_ready;

    always_comb begin
        state_next = state_reg;
        iter_next  = iter_reg;
        k_next     = k_reg;
        sel_next   = sel_reg;
        goal_next  = goal_reg;
        cmd        = '0;
        cmd.iter   = iter_reg;
        cmd.sel    = sel_reg;
        cmd.div_k  = k_reg;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    cmd.load_in = 1'b1;
                    goal_next   = (s_op == wpi_pkg::OP_GOAL);
                    iter_next   = '0;
                    case (s_op)
                        wpi_pkg::OP_START:                  state_next = S_START;
                        wpi_pkg::OP_WAYPOINT, wpi_pkg::OP_GOAL: state_next = S_CORDIC;
                        default:                            state_next = S_IDLE;
                    endcase
                end
            end
            S_START: begin
                if (status.out_free) begin
                    cmd.emit_start = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_CORDIC: begin
                cmd.cordic_step = 1'b1;
                iter_next       = iter_reg + 1'b1;
                if (iter_reg == wpi_pkg::ITER_W'(CORDIC_STEPS - 1)) begin
                    sel_next   = wpi_pkg::SEL_LEN;
                    state_next = S_MLO;
                end
            end
            S_MLO: begin
                cmd.mul_lo = 1'b1;
                state_next = S_MHI;
            end
            S_MHI: begin
                cmd.mul_hi = 1'b1;
                case (sel_reg)
                    wpi_pkg::SEL_LEN: begin
                        sel_next   = wpi_pkg::SEL_X;
                        state_next = S_MLO;
                    end
                    wpi_pkg::SEL_X: begin
                        sel_next   = wpi_pkg::SEL_Y;
                        state_next = S_MLO;
                    end
                    default: state_next = S_DIVI;
                endcase
            end
            S_DIVI: begin
                cmd.div_init = 1'b1;
                k_next       = wpi_pkg::KBIT_W'(wpi_pkg::QUOT_W - 1);
                state_next   = S_DIV;
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                k_next       = k_reg - 1'b1;
                if (k_reg == '0) begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT: begin
                if (status.cnt_zero) begin
                    cmd.commit_anchor = 1'b1;
                    state_next        = goal_reg ? S_GOAL : S_IDLE;
                end else if (status.out_free) begin
                    cmd.emit_point = 1'b1;
                    cmd.emit_last  = status.cnt_one && !goal_reg;
                end
            end
            S_GOAL: begin
                if (status.out_free) begin
                    cmd.emit_goal = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            iter_reg  <= '0;
            k_reg     <= '0;
            sel_reg   <= wpi_pkg::SEL_LEN;
            goal_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            iter_reg  <= iter_next;
            k_reg     <= k_next;
            sel_reg   <= sel_next;
            goal_reg  <= goal_next;
        end
    end

endmodule

// ===== rtl/wpi_dp.sv =====
// ----------------------------------------------------------------------------
// wpi_dp
// Datapath: CORDIC, shared gain multiplier, count divider, cursor, output.
// ----------------------------------------------------------------------------
module wpi_dp #(
    parameter int unsigned MAX_SEGMENT_POINTS = 63
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  wpi_pkg::dp_cmd_t     cmd,
    output wpi_pkg::dp_status_t  status,
    input  logic [31:0]          step_length,
    input  logic signed [31:0]   s_in_x,
    input  logic signed [31:0]   s_in_y,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic signed [31:0]   m_out_x,
    output logic signed [31:0]   m_out_y,
    output logic                 m_run_last,
    output logic                 m_path_end,
    output logic                 m_count_clipped
);

    localparam int unsigned CW = wpi_pkg::CORD_W;
    localparam int unsigned RW = wpi_pkg::REM_W;
    localparam logic [wpi_pkg::CNT_W-1:0] MAX_CNT = wpi_pkg::CNT_W'(MAX_SEGMENT_POINTS);

    logic [31:0]          pt_x_reg, pt_y_reg, anchor_x_reg, anchor_y_reg;
    logic [31:0]          cursor_x_reg, cursor_y_reg, ax_reg, ay_reg;
    logic signed [CW-1:0] vx_reg, vy_reg, rx_reg, ry_reg;
    logic                 flip_reg;
    logic [61:0]          plo_reg;
    logic [CW-1:0]        len_reg;
    logic [RW-1:0]        rem_reg;
    logic [wpi_pkg::QUOT_W-1:0] q_reg;
    logic                 big_reg;
    logic [wpi_pkg::CNT_W-1:0] cnt_reg;
    logic                 clip_reg;
    logic                 valid_reg;
    logic [31:0]          ox_reg, oy_reg;
    logic                 last_reg, end_reg, oclip_reg;

    logic signed [32:0]   dx, dy;
    logic signed [CW-1:0] dx_e, dy_e, svx, svy, srx, sry;
    logic                 dir;
    logic [CW-1:0]        mag;
    logic                 mag_neg;
    logic [33:0]          phi;
    logic [65:0]          total;
    logic [CW-1:0]        res;
    logic [31:0]          res_s;
    logic [31:0]          step_eff;
    logic [RW-1:0]        trial;
    logic                 take;
    logic [wpi_pkg::QUOT_W-1:0] q_fin;
    logic                 clip_fin;
    logic [31:0]          cx_n, cy_n;

    assign dx   = 33'(signed'(s_in_x)) - 33'(signed'(anchor_x_reg));
    assign dy   = 33'(signed'(s_in_y)) - 33'(signed'(anchor_y_reg));
    assign dx_e = CW'(dx);
    assign dy_e = CW'(dy);

    assign svx = vx_reg >>> cmd.iter;
    assign svy = vy_reg >>> cmd.iter;
    assign srx = rx_reg >>> cmd.iter;
    assign sry = ry_reg >>> cmd.iter;
    assign dir = !vy_reg[CW-1];

    always_comb begin
        case (cmd.sel)
            wpi_pkg::SEL_LEN: begin
                mag     = vx_reg[CW-1] ? '0 : CW'(vx_reg);
                mag_neg = 1'b0;
            end
            wpi_pkg::SEL_X: begin
                mag     = rx_reg[CW-1] ? CW'(-rx_reg) : CW'(rx_reg);
                mag_neg = rx_reg[CW-1] ^ flip_reg;
            end
            default: begin
                mag     = ry_reg[CW-1] ? CW'(-ry_reg) : CW'(ry_reg);
                mag_neg = ry_reg[CW-1] ^ flip_reg;
            end
        endcase
    end

    assign phi   = {30'd0, mag[CW-1:32]} * {4'd0, wpi_pkg::GAIN_INV_Q30};
    assign total = {4'd0, plo_reg} + {phi, 32'd0};
    assign res   = total[65:30];
    assign res_s = mag_neg ? 32'(-res[31:0]) : res[31:0];

    assign step_eff = (step_length == '0) ? 32'd1 : step_length;
    assign trial    = {8'd0, step_eff} << cmd.div_k;
    assign take     = (rem_reg >= trial);
    assign q_fin    = q_reg | (wpi_pkg::QUOT_W'(take) << cmd.div_k);
    assign clip_fin = big_reg || (q_fin > wpi_pkg::QUOT_W'(MAX_SEGMENT_POINTS));

    assign cx_n = cursor_x_reg + ax_reg;
    assign cy_n = cursor_y_reg + ay_reg;

    assign status.out_free = !valid_reg || m_ready;
    assign status.cnt_zero = (cnt_reg == '0);
    assign status.cnt_one  = (cnt_reg == wpi_pkg::CNT_W'(1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            anchor_x_reg <= '0;
            anchor_y_reg <= '0;
            cursor_x_reg <= '0;
            cursor_y_reg <= '0;
            cnt_reg      <= '0;
            clip_reg     <= 1'b0;
            valid_reg    <= 1'b0;
        end else begin
            if (cmd.load_in) begin
                pt_x_reg <= s_in_x;
                pt_y_reg <= s_in_y;
                flip_reg <= dx[32];
                vx_reg   <= dx[32] ? -dx_e : dx_e;
                vy_reg   <= dx[32] ? -dy_e : dy_e;
                rx_reg   <= CW'(step_eff);
                ry_reg   <= '0;
            end
            if (cmd.cordic_step) begin
                if (dir) begin
                    vx_reg <= vx_reg + svy;
                    vy_reg <= vy_reg - svx;
                    rx_reg <= rx_reg - sry;
                    ry_reg <= ry_reg + srx;
                end else begin
                    vx_reg <= vx_reg - svy;
                    vy_reg <= vy_reg + svx;
                    rx_reg <= rx_reg + sry;
                    ry_reg <= ry_reg - srx;
                end
            end
            if (cmd.mul_lo) begin
                plo_reg <= {30'd0, mag[31:0]} * {32'd0, wpi_pkg::GAIN_INV_Q30};
            end
            if (cmd.mul_hi) begin
                case (cmd.sel)
                    wpi_pkg::SEL_LEN: len_reg <= res;
                    wpi_pkg::SEL_X:   ax_reg  <= res_s;
                    default:          ay_reg  <= res_s;
                endcase
            end
            if (cmd.div_init) begin
                rem_reg <= {4'd0, len_reg};
                q_reg   <= '0;
                big_reg <= ({4'd0, len_reg} >= {1'b0, step_eff, 7'd0});
            end
            if (cmd.div_step) begin
                if (take) begin
                    rem_reg <= rem_reg - trial;
                end
                q_reg <= q_fin;
                if (cmd.div_k == '0) begin
                    cnt_reg  <= clip_fin ? MAX_CNT : q_fin[wpi_pkg::CNT_W-1:0];
                    clip_reg <= clip_fin;
                end
            end
            if (cmd.commit_anchor) begin
                anchor_x_reg <= pt_x_reg;
                anchor_y_reg <= pt_y_reg;
            end
            if (cmd.emit_start) begin
                anchor_x_reg <= pt_x_reg;
                anchor_y_reg <= pt_y_reg;
                cursor_x_reg <= pt_x_reg;
                cursor_y_reg <= pt_y_reg;
                ox_reg       <= pt_x_reg;
                oy_reg       <= pt_y_reg;
                last_reg     <= 1'b1;
                end_reg      <= 1'b0;
                oclip_reg    <= 1'b0;
            end
            if (cmd.emit_point) begin
                cursor_x_reg <= cx_n;
                cursor_y_reg <= cy_n;
                cnt_reg      <= cnt_reg - 1'b1;
                ox_reg       <= cx_n;
                oy_reg       <= cy_n;
                last_reg     <= cmd.emit_last;
                end_reg      <= 1'b0;
                oclip_reg    <= clip_reg;
            end
            if (cmd.emit_goal) begin
                ox_reg    <= pt_x_reg;
                oy_reg    <= pt_y_reg;
                last_reg  <= 1'b1;
                end_reg   <= 1'b1;
                oclip_reg <= clip_reg;
            end
            if (cmd.emit_start || cmd.emit_point || cmd.emit_goal) begin
                valid_reg <= 1'b1;
            end else if (m_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid         = valid_reg;
    assign m_out_x         = ox_reg;
    assign m_out_y         = oy_reg;
    assign m_run_last      = last_reg;
    assign m_path_end      = end_reg;
    assign m_count_clipped = oclip_reg;

endmodule

// ===== rtl/waypoint_path_interpolator_top.sv =====
// ----------------------------------------------------------------------------
// waypoint_path_interpolator_top
// Linear path interpolation between waypoints with CORDIC direction finding.
//
//   channel | ports            | moves
//   --------+------------------+----------------------------------------
//   input   | s_valid/s_ready  | item: op, in_x, in_y
//   output  | m_valid/m_ready  | item: out_x, out_y, run_last, path_end,
//           |                  |       count_clipped
//   config  | APB psel/penable | step_length at address 0
//
// A start item emits one point. A segment runs through the serial CORDIC, the
// shared gain multiplier (two passes per value) and the 7-step count divider,
// then emits its points one at a time, and a goal item adds the goal point.
// Reset clears the anchor, the cursor and the output valid flag.
// A stalled output holds the sequencer; one finished item waits in the
// output register while the next input item is accepted.
// ----------------------------------------------------------------------------
module waypoint_path_interpolator_top #(
    parameter int unsigned MAX_SEGMENT_POINTS = 63,
    parameter int unsigned CORDIC_STEPS       = 24
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_op,
    input  logic signed [31:0] s_in_x,
    input  logic signed [31:0] s_in_y,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_out_x,
    output logic signed [31:0] m_out_y,
    output logic               m_run_last,
    output logic               m_path_end,
    output logic               m_count_clipped
);

    logic [31:0]         step_reg;
    wpi_pkg::dp_cmd_t    cmd;
    wpi_pkg::dp_status_t status;

    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'd0 : step_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= wpi_pkg::STEP_RESET;
        end else if (psel && penable && pwrite && !paddr[2]) begin
            step_reg <= pwdata;
        end
    end

    wpi_ctrl #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_op    (s_op),
        .status  (status),
        .cmd     (cmd)
    );

    wpi_dp #(
        .MAX_SEGMENT_POINTS (MAX_SEGMENT_POINTS)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .status          (status),
        .step_length     (step_reg),
        .s_in_x          (s_in_x),
        .s_in_y          (s_in_y),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_x         (m_out_x),
        .m_out_y         (m_out_y),
        .m_run_last      (m_run_last),
        .m_path_end      (m_path_end),
        .m_count_clipped (m_count_clipped)
    );

endmodule

// ===== rtl/wpi_chk.sv =====
// ----------------------------------------------------------------------------
// wpi_chk
// Port-level checks for the waypoint path interpolator.
// ----------------------------------------------------------------------------
module wpi_chk (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic [1:0]  s_op,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_run_last,
    input logic        m_path_end
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("output item dropped while stalled");

    a_end_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_path_end |-> m_run_last)
        else $error("goal point not last of its item");

    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_op != wpi_pkg::OP_NONE) |=> !s_ready)
        else $error("input taken while item in progress");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid after reset");

endmodule

bind waypoint_path_interpolator_top wpi_chk u_chk (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .s_valid    (s_valid),
    .s_ready    (s_ready),
    .s_op       (s_op),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_run_last (m_run_last),
    .m_path_end (m_path_end)
);

// ===== sim/wpi_checker.sv =====
// ----------------------------------------------------------------------------
// wpi_checker
// Watches both item channels and the configuration port of the waypoint path
// interpolator, predicts every emitted path point from the accepted input
// items and compares each result item field by field.
// ----------------------------------------------------------------------------
module wpi_checker #(
    parameter int unsigned MAX_SEGMENT_POINTS = 63,
    parameter int unsigned CORDIC_STEPS       = 24
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    input  logic               pready,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic [1:0]         s_op,
    input  logic signed [31:0] s_in_x,
    input  logic signed [31:0] s_in_y,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic signed [31:0] m_out_x,
    input  logic signed [31:0] m_out_y,
    input  logic               m_run_last,
    input  logic               m_path_end,
    input  logic               m_count_clipped,
    output int                 fail_count,
    output int                 pending_points
);

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic        last;
        logic        goal;
        logic        clipped;
    } path_point_t;

    path_point_t expected_points[$];
    logic [31:0] spacing;
    logic [31:0] cur_x, cur_y, anc_x, anc_y;

    function automatic longint shr_floor(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint gain_scale(longint v);
        longint unsigned m;
        m = (v < 0) ? longint'(-v) : longint'(v);
        m = (m * 64'd652032874) >> 30;
        return (v < 0) ? -longint'(m) : longint'(m);
    endfunction

    task automatic add_expected(input path_point_t p);
        expected_points = {expected_points, p};
    endtask

    task automatic interpolate(input wpi_pkg::op_t op, input logic [31:0] px,
                               input logic [31:0] py);
        longint dx, dy, vx, vy, sx, sy, rx, ry;
        longint unsigned len, stride, cnt;
        logic [63:0] dirs;
        logic flip, clip;
        int first;
        path_point_t p;
        first = expected_points.size();
        if (op == wpi_pkg::OP_NONE) return;
        if (op == wpi_pkg::OP_START) begin
            cur_x = px; anc_x = px; cur_y = py; anc_y = py;
            p = '{px, py, 1'b1, 1'b0, 1'b0};
            add_expected(p);
            return;
        end
        dx = longint'($signed(px)) - longint'($signed(anc_x));
        dy = longint'($signed(py)) - longint'($signed(anc_y));
        flip = dx < 0;
        vx = flip ? -dx : dx;
        vy = flip ? -dy : dy;
        dirs = '0;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            sx = shr_floor(vx, i); sy = shr_floor(vy, i);
            if (vy >= 0) begin
                vx += sy; vy -= sx; dirs[i] = 1'b1;
            end else begin
                vx -= sy; vy += sx;
            end
        end
        len = (longint'(vx < 0 ? 0 : vx) * 64'd652032874) >> 30;
        stride = (spacing == 0) ? 1 : spacing;
        cnt = len / stride;
        clip = cnt > MAX_SEGMENT_POINTS;
        if (clip) cnt = MAX_SEGMENT_POINTS;
        rx = stride; ry = 0;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            sx = shr_floor(rx, i); sy = shr_floor(ry, i);
            if (dirs[i]) begin
                rx -= sy; ry += sx;
            end else begin
                rx += sy; ry -= sx;
            end
        end
        rx = gain_scale(rx);
        ry = gain_scale(ry);
        if (flip) begin
            rx = -rx; ry = -ry;
        end
        for (longint unsigned j = 0; j < cnt; j++) begin
            cur_x += rx[31:0];
            cur_y += ry[31:0];
            p = '{cur_x, cur_y, 1'b0, 1'b0, clip};
            add_expected(p);
        end
        anc_x = px; anc_y = py;
        if (op == wpi_pkg::OP_GOAL) begin
            p = '{px, py, 1'b0, 1'b1, clip};
            add_expected(p);
        end
        if (expected_points.size() > first)
            expected_points[expected_points.size()-1].last = 1'b1;
    endtask

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    initial begin
        fail_count = 0;
        pending_points = 0;
    end

    always @(posedge aclk) begin
        path_point_t want;
        if (!aresetn) begin
            spacing = wpi_pkg::STEP_RESET;
            cur_x = '0; cur_y = '0; anc_x = '0; anc_y = '0;
            expected_points.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (expected_points.size() == 0) begin
                    report("unexpected item", m_out_x, '0);
                end else begin
                    want = expected_points.pop_front();
                    if (m_out_x !== want.x) report("out_x", m_out_x, want.x);
                    if (m_out_y !== want.y) report("out_y", m_out_y, want.y);
                    if (m_run_last !== want.last) report("run_last", m_run_last, want.last);
                    if (m_path_end !== want.goal) report("path_end", m_path_end, want.goal);
                    if (m_count_clipped !== want.clipped)
                        report("count_clipped", m_count_clipped, want.clipped);
                end
            end
            if (s_valid && s_ready) interpolate(wpi_pkg::op_t'(s_op), s_in_x, s_in_y);
            if (psel && penable && pwrite && pready && !paddr[2]) spacing = pwdata;
        end
        pending_points = expected_points.size();
    end

endmodule

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives start, waypoint and goal items with random gaps and output stalls,
// sweeps the point spacing through its extremes and reports the verdict.
// ----------------------------------------------------------------------------
module testbench;

    localparam int CYCLE_LIMIT = 1500000;

    logic               aclk;
    logic               aresetn;
    logic               psel, penable, pwrite;
    logic [2:0]         paddr;
    logic [31:0]        pwdata, prdata;
    logic               pready;
    logic               s_valid, s_ready;
    logic [1:0]         s_op;
    logic signed [31:0] s_in_x, s_in_y;
    logic               m_valid, m_ready;
    logic signed [31:0] m_out_x, m_out_y;
    logic               m_run_last, m_path_end, m_count_clipped;
    int                 fail_count, pending_points;
    int                 cycles;
    logic               hold_output;
    logic [31:0]        px, py;

    waypoint_path_interpolator_top dut (.*);
    wpi_checker chk (.*);

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge aclk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial begin
        int gap;
        m_ready = 1'b0;
        hold_output = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_output) begin
                m_ready <= 1'b0;
            end else if (m_ready && m_valid || !m_ready) begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
                if (gap > 0) begin
                    m_ready <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
                m_ready <= 1'b1;
            end
        end
    end

    task automatic write_spacing(input logic [31:0] value);
        @(posedge aclk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= 3'd0; pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    task automatic drain;
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_points != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
    endtask

    task automatic send_item(input wpi_pkg::op_t op, input logic [31:0] x,
                             input logic [31:0] y, input bit paced);
        int gap;
        gap = paced ? $urandom_range(0, 8) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1; s_op <= op; s_in_x <= x; s_in_y <= y;
        do @(posedge aclk); while (!s_ready);
    endtask

    function automatic logic [31:0] near(input logic [31:0] base);
        return base + $signed($urandom_range(0, 32'h000C_0000)) - 32'sh0006_0000;
    endfunction

    initial begin
        logic [31:0] spacing_set[5];
        int n;
        wpi_pkg::op_t op;
        spacing_set = '{32'd6554, 32'd0, 32'hFFFF_FFFF, 32'd1, 32'h0000_8000};
        aresetn = 1'b0;
        psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
        s_valid = 0; s_op = wpi_pkg::OP_START; s_in_x = 0; s_in_y = 0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: segments without a start, zero length, extremes, unused op
        send_item(wpi_pkg::OP_WAYPOINT, 32'h0001_0000, 32'h0000_0000, 1);
        send_item(wpi_pkg::OP_GOAL, 32'h0001_0000, 32'h0000_0000, 1);
        send_item(wpi_pkg::OP_NONE, 32'h1234_5678, 32'h8765_4321, 1);
        send_item(wpi_pkg::OP_START, 32'h8000_0000, 32'h7FFF_FFFF, 1);
        send_item(wpi_pkg::OP_WAYPOINT, 32'h7FFF_FFFF, 32'h8000_0000, 1);
        send_item(wpi_pkg::OP_GOAL, 32'h8000_0000, 32'h8000_0000, 1);
        send_item(wpi_pkg::OP_START, 32'h0, 32'h0, 1);
        send_item(wpi_pkg::OP_WAYPOINT, 32'hFFFF_0000, 32'h0000_8000, 1);
        send_item(wpi_pkg::OP_WAYPOINT, 32'hFFFF_0000, 32'hFFFF_0000, 1);
        send_item(wpi_pkg::OP_GOAL, 32'h0000_4000, 32'hFFFF_C000, 1);
        drain();
        write_spacing(32'd0);
        send_item(wpi_pkg::OP_START, 32'h0, 32'h0, 1);
        send_item(wpi_pkg::OP_GOAL, 32'h0000_0020, 32'hFFFF_FFE0, 1);
        drain();
        write_spacing(32'hFFFF_FFFF);
        send_item(wpi_pkg::OP_START, 32'h7FFF_FFFF, 32'h0, 1);
        send_item(wpi_pkg::OP_GOAL, 32'h8000_0000, 32'h0, 1);
        drain();

        // long output stall while items keep coming
        write_spacing(32'd6554);
        hold_output = 1'b1;
        fork
            begin
                send_item(wpi_pkg::OP_START, 32'h0, 32'h0, 0);
                send_item(wpi_pkg::OP_WAYPOINT, 32'h0000_8000, 32'h0000_4000, 0);
                send_item(wpi_pkg::OP_WAYPOINT, 32'h0001_0000, 32'h0, 0);
                send_item(wpi_pkg::OP_GOAL, 32'h0, 32'h0001_0000, 0);
                s_valid <= 1'b0;
            end
            begin
                repeat (600) @(posedge aclk);
                hold_output = 1'b0;
            end
        join
        drain();

        n = 0;
        for (int phase = 0; phase < 5; phase++) begin
            write_spacing(spacing_set[phase]);
            while (n < (phase + 1) * 60) begin
                px = $urandom; py = $urandom;
                if ($urandom_range(0, 9) == 0) begin
                    op = wpi_pkg::op_t'($urandom_range(0, 3));
                    send_item(op, $urandom, $urandom, 1);
                    n++;
                    continue;
                end
                send_item(wpi_pkg::OP_START, px, py, 1);
                n++;
                repeat ($urandom_range(0, 4)) begin
                    px = near(px); py = near(py);
                    send_item(wpi_pkg::OP_WAYPOINT, px, py, 1);
                    n++;
                end
                send_item(wpi_pkg::OP_GOAL, near(px), near(py), 1);
                n++;
            end
            drain();
        end

        while (pending_points != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
